/* design/ipv4_tcp_checksum_stream_assert.svh */
// Assertion macros shared by the checksum stream RTL.
// Expects clk and rst in the scope of each use.
`ifndef IPV4_TCP_CHECKSUM_STREAM_ASSERT_SVH
`define IPV4_TCP_CHECKSUM_STREAM_ASSERT_SVH

// pre holds in a cycle, post holds in the same cycle
`define ITCS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// pre holds in a cycle, post holds in the next cycle
`define ITCS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/itcs_pkg.sv */
// Types, constants and one's-complement add for the checksum stream.
// No dependencies.
`default_nettype none

package itcs_pkg;

  localparam logic [15:0] SUM_MASK      = 16'hFFFF;
  localparam logic [15:0] HDR_MIN_BYTES = 16'd20;
  localparam logic [15:0] IP_CKS_HI     = 16'd10;
  localparam logic [15:0] IP_CKS_LO     = 16'd11;
  localparam logic [15:0] IP_ADDR_FIRST = 16'd12;
  localparam logic [15:0] IP_ADDR_END   = 16'd20;
  localparam logic [15:0] TCP_OFF_POS   = 16'd12;
  localparam logic [15:0] TCP_CKS_HI    = 16'd16;
  localparam logic [15:0] TCP_CKS_LO    = 16'd17;
  localparam logic [7:0]  TCP_PROTO     = 8'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_IP_SHORT = 2'd1;
  localparam logic [1:0] ST_TCP_BAD  = 2'd2;
  localparam logic [1:0] ST_IP_CUT   = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last;
  } byte_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] sum;
    logic [7:0]  held;
    logic [15:0] seg;
    logic [1:0]  status;
  } fin_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

/* design/itcs_accum.sv */
// Per-byte accumulator: header parsing, running one's-complement sum,
// and capture of packet totals on the last byte. Uses itcs_pkg.
`default_nettype none

module itcs_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              rin_valid,
  input  itcs_pkg::byte_t   rin,
  input  logic              fin_ready,
  output logic              rin_take,
  output logic              fin_valid,
  output itcs_pkg::fin_t    fin
);
  import itcs_pkg::*;

  logic [15:0] run_sum;
  logic [7:0]  held_high_byte;
  logic [15:0] byte_position;
  logic [15:0] segment_length;
  logic [3:0]  ip_header_words;
  logic [3:0]  tcp_header_words;
  logic        mode_latch;
  logic        in_packet;

  logic        first;
  logic        mode_e;
  logic [15:0] sum_e;
  logic [7:0]  held_e;
  logic [15:0] pos;
  logic [15:0] seg_e;
  logic [3:0]  thw_e;
  logic [3:0]  ihw_next;
  logic [3:0]  thw_next;
  logic [15:0] ihl;
  logic [15:0] thl;
  logic [15:0] tpos;
  logic [15:0] tbytes;
  logic        feed_en;
  logic        feed_odd;
  logic [7:0]  feed_val;
  logic [15:0] sum_next;
  logic [7:0]  held_next;
  logic [15:0] seg_next;
  logic [15:0] pos_next;
  logic [1:0]  status_next;

  always_comb begin
    first    = !in_packet;
    mode_e   = first ? rin.mode : mode_latch;
    sum_e    = first ? 16'd0 : run_sum;
    held_e   = first ? 8'd0 : held_high_byte;
    pos      = first ? 16'd0 : byte_position;
    seg_e    = first ? 16'd0 : segment_length;
    thw_e    = first ? 4'd0 : tcp_header_words;
    ihw_next = (pos == 16'd0) ? rin.data_byte[3:0] : (first ? 4'd0 : ip_header_words);
    ihl      = {10'd0, ihw_next, 2'b00};
    tpos     = pos - ihl;
    thw_next = thw_e;
    seg_next = seg_e;
    feed_en  = 1'b0;
    feed_odd = 1'b0;
    feed_val = rin.data_byte;
    if (!mode_e) begin
      if (pos < ihl) begin
        feed_en  = 1'b1;
        feed_odd = pos[0];
        if (pos == IP_CKS_HI || pos == IP_CKS_LO) feed_val = 8'd0;
      end
    end else if (pos >= ihl) begin
      if (tpos == TCP_OFF_POS) thw_next = rin.data_byte[7:4];
      feed_en  = 1'b1;
      feed_odd = seg_e[0];
      if (tpos == TCP_CKS_HI || tpos == TCP_CKS_LO) feed_val = 8'd0;
      seg_next = seg_e + 16'd1;
    end else if (pos >= IP_ADDR_FIRST && pos < IP_ADDR_END) begin
      feed_en  = 1'b1;
      feed_odd = pos[0];
    end
    sum_next  = sum_e;
    held_next = held_e;
    if (feed_en) begin
      if (!feed_odd) held_next = feed_val;
      else sum_next = oc_add(sum_e, {held_e, feed_val});
    end
    pos_next = (pos == SUM_MASK) ? pos : pos + 16'd1;
    thl      = {10'd0, thw_next, 2'b00};
    tbytes   = pos_next - ihl;
    if (ihl < HDR_MIN_BYTES) begin
      status_next = ST_IP_SHORT;
    end else if (pos_next < ihl) begin
      status_next = ST_IP_CUT;
    end else if (mode_e && (tbytes < HDR_MIN_BYTES || thl < HDR_MIN_BYTES || tbytes < thl)) begin
      status_next = ST_TCP_BAD;
    end else begin
      status_next = ST_OK;
    end
  end

  assign rin_take = rin_valid && (!rin.last || !fin_valid || fin_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum          <= 16'd0;
      held_high_byte   <= 8'd0;
      byte_position    <= 16'd0;
      segment_length   <= 16'd0;
      ip_header_words  <= 4'd0;
      tcp_header_words <= 4'd0;
      mode_latch       <= 1'b0;
      in_packet        <= 1'b0;
    end else if (rin_take) begin
      run_sum          <= sum_next;
      held_high_byte   <= held_next;
      byte_position    <= pos_next;
      segment_length   <= seg_next;
      ip_header_words  <= ihw_next;
      tcp_header_words <= thw_next;
      mode_latch       <= mode_e;
      in_packet        <= !rin.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (rin_take && rin.last) begin
      fin_valid <= 1'b1;
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rin_take && rin.last) begin
      fin.mode   <= mode_e;
      fin.sum    <= sum_next;
      fin.held   <= held_next;
      fin.seg    <= seg_next;
      fin.status <= status_next;
    end
  end

`include "ipv4_tcp_checksum_stream_assert.svh"

  `ITCS_ASSERT_NXT(a_last_makes_fin, rin_take && rin.last, fin_valid, "last byte lost")
  `ITCS_ASSERT_NXT(a_fin_holds, fin_valid && !fin_ready, fin_valid && $stable(fin), "fin changed")
  `ITCS_ASSERT_NXT(a_last_ends_packet, rin_take && rin.last, !in_packet, "packet not closed")

endmodule

`default_nettype wire

/* design/itcs_final.sv */
// Final fold of pseudo-header terms (TCP mode only) and complement into the
// result register; an error status gives zero. Uses itcs_pkg.
`default_nettype none

module itcs_final (
  input  logic            clk,
  input  logic            rst,
  input  logic            fin_valid,
  input  itcs_pkg::fin_t  fin,
  output logic            fin_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     checksum,
  output logic [1:0]      status
);
  import itcs_pkg::*;

  logic [15:0] pad;
  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] sum_final;
  logic [15:0] checksum_next;

  always_comb begin
    pad       = {(fin.seg[0] ? fin.held : 8'd0), TCP_PROTO};
    total     = {2'b00, fin.sum} + {2'b00, pad} + {2'b00, fin.seg};
    fold1     = {1'b0, total[15:0]} + {15'd0, total[17:16]};
    fold2     = fold1[15:0] + {15'd0, fold1[16]};
    sum_final = fin.mode ? fold2 : fin.sum;
    checksum_next = (fin.status == ST_OK) ? ~sum_final : 16'd0;
  end

  assign fin_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      checksum <= checksum_next;
      status   <= fin.status;
    end
  end

`include "ipv4_tcp_checksum_stream_assert.svh"

  `ITCS_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK, checksum == 16'd0, "nonzero on error")
  `ITCS_ASSERT_NXT(a_fin_to_out, fin_valid && fin_ready, out_valid, "result dropped")
  `ITCS_ASSERT_NXT(a_out_holds, out_valid && out_stall, out_valid && $stable(checksum) && $stable(status), "result changed while stalled")

endmodule

`default_nettype wire

/* design/ipv4_tcp_checksum_stream.sv */
// Streaming IPv4 header / TCP checksum, top level with input register.
// Uses itcs_pkg, itcs_accum, itcs_final.
//
// Input channel: one packet byte per transaction (mode, data_byte, last),
// IP header first, then the TCP segment. mode is taken from the first byte
// of each packet. Output channel: one transaction per packet (checksum,
// status), produced for the byte marked last.
// The last byte passes the input register, the fin register and the result register in turn.
// Throughput: one byte per cycle while in_stall is low; each summed byte pair costs one 16-bit
// end-around-carry add in the accumulator stage, and packets may follow each other directly.
// Reset (rst, synchronous): empties the pipeline and starts a new packet with
// the next byte.
// Stall: while out_stall holds, the result register keeps its transaction,
// one more finished packet waits in the stage behind it, and non-last bytes
// keep flowing; in_stall rises only when a last byte finds both stages full.
`default_nettype none

module ipv4_tcp_checksum_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] checksum,
  output logic [1:0]  status
);
  import itcs_pkg::*;

  logic  rin_valid;
  byte_t rin;
  logic  rin_take;
  logic  fin_valid;
  fin_t  fin;
  logic  fin_ready;

  assign in_stall = rin_valid && !rin_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      rin_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      rin_valid <= 1'b1;
    end else if (rin_take) begin
      rin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rin.mode      <= mode;
      rin.data_byte <= data_byte;
      rin.last      <= last;
    end
  end

  itcs_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .rin_valid (rin_valid),
    .rin       (rin),
    .fin_ready (fin_ready),
    .rin_take  (rin_take),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  itcs_final u_final (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .checksum  (checksum),
    .status    (status)
  );

endmodule

`default_nettype wire

/* tb/tb_ipv4_tcp_checksum_stream.sv */
// Self-checking testbench for ipv4_tcp_checksum_stream: directed table, then random packets.
// Predicts checksum and status per packet and compares each result transaction in order.
// Depends on itcs_pkg and the ipv4_tcp_checksum_stream RTL.
module tb_ipv4_tcp_checksum_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import itcs_pkg::*;

  localparam logic MODE_IP  = 1'b0;
  localparam logic MODE_TCP = 1'b1;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_BYTES   = 1000;
  localparam int PHASE_PACKETS  = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic        md;
    logic [7:0]  d;
    logic        lst;
    logic        typed;
    logic [15:0] cks;
    logic [1:0]  st;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] cks;
    logic [1:0]  st;
  } cks_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] checksum;
  logic [1:0]  status;

  // packet state of the predictor
  logic [15:0] acc_sum;
  logic [7:0]  acc_hi;
  logic [15:0] byte_cnt;
  logic [15:0] seg_len;
  logic [3:0]  ihl_words;
  logic [3:0]  thl_words;
  logic        pkt_mode;
  logic        pkt_open = 1'b0;

  cks_result_t cks_expected[$];
  cks_result_t want;
  logic [7:0]  pkt_bytes[$];
  logic        pkt_md;

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  dir_row_t dir_tab [24] = '{
    '{MODE_IP,  8'h45, 1'b1, 1'b1, 16'h0000, ST_IP_CUT},
    '{MODE_TCP, 8'h00, 1'b1, 1'b1, 16'h0000, ST_IP_SHORT},
    '{MODE_IP,  8'hFF, 1'b1, 1'b1, 16'h0000, ST_IP_CUT},
    '{MODE_TCP, 8'h44, 1'b1, 1'b1, 16'h0000, ST_IP_SHORT},
    '{MODE_IP,  8'h45, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'h00, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h00, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'h3C, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'hFF, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'hFF, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h40, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'h00, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h40, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h06, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'hAB, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'hCD, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'hC0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'hA8, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'h00, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h01, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h0A, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'h00, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_IP,  8'h00, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{MODE_TCP, 8'hFF, 1'b1, 1'b0, 16'h0000, ST_OK}
  };

  ipv4_tcp_checksum_stream dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .checksum  (checksum),
    .status    (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic add_byte(input logic odd, input logic [7:0] v);
    if (!odd) begin
      acc_hi = v;
    end else begin
      acc_sum = fold_add(acc_sum, {acc_hi, v});
    end
  endtask

  task automatic predict_checksum(input logic md, input logic [7:0] d, input logic lst,
                                  output logic produced, output cks_result_t res);
    logic [15:0] pos;
    logic [15:0] ihl_b;
    logic [15:0] thl_b;
    logic [15:0] ofs;
    logic [15:0] sum;
    logic [1:0]  st;
    produced = 1'b0;
    res = '0;
    if (!pkt_open) begin
      acc_sum   = '0;
      acc_hi    = '0;
      byte_cnt  = '0;
      seg_len   = '0;
      ihl_words = '0;
      thl_words = '0;
      pkt_mode  = md;
      pkt_open  = 1'b1;
    end
    pos = byte_cnt;
    if (pos == 16'd0) ihl_words = d[3:0];
    ihl_b = {10'd0, ihl_words, 2'b00};
    if (pkt_mode == MODE_IP) begin
      if (pos < ihl_b) add_byte(pos[0], (pos == IP_CKS_HI || pos == IP_CKS_LO) ? 8'h00 : d);
    end else if (pos >= ihl_b) begin
      ofs = pos - ihl_b;
      if (ofs == TCP_OFF_POS) thl_words = d[7:4];
      add_byte(seg_len[0], (ofs == TCP_CKS_HI || ofs == TCP_CKS_LO) ? 8'h00 : d);
      seg_len = seg_len + 16'd1;
    end else if (pos >= IP_ADDR_FIRST && pos < IP_ADDR_END) begin
      add_byte(pos[0], d);
    end
    if (byte_cnt != SUM_MASK) byte_cnt = byte_cnt + 16'd1;
    if (lst) begin
      st = ST_OK;
      thl_b = {10'd0, thl_words, 2'b00};
      if (ihl_b < HDR_MIN_BYTES) begin
        st = ST_IP_SHORT;
      end else if (byte_cnt < ihl_b) begin
        st = ST_IP_CUT;
      end else if (pkt_mode == MODE_TCP && (byte_cnt - ihl_b < HDR_MIN_BYTES ||
                   thl_b < HDR_MIN_BYTES || byte_cnt - ihl_b < thl_b)) begin
        st = ST_TCP_BAD;
      end
      if (st == ST_OK) begin
        sum = acc_sum;
        if (pkt_mode == MODE_TCP) begin
          if (seg_len[0]) sum = fold_add(sum, {acc_hi, 8'h00});
          sum = fold_add(sum, {8'h00, TCP_PROTO});
          sum = fold_add(sum, seg_len);
        end
        res.cks = ~sum;
      end
      res.st = st;
      produced = 1'b1;
      pkt_open = 1'b0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic md, input logic [7:0] d, input logic lst,
                           input logic typed, input logic [15:0] tcks, input logic [1:0] tst);
    logic        produced;
    cks_result_t res;
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= md;
    data_byte <= d;
    last      <= lst;
    do @(posedge clk); while (in_stall);
    predict_checksum(md, d, lst, produced, res);
    if (produced) begin
      if (typed) begin
        res.cks = tcks;
        res.st  = tst;
      end
      cks_expected.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_byte((i == 0) ? pkt_md : 1'($urandom_range(0, 1)), pkt_bytes[i],
                i == pkt_bytes.size() - 1, 1'b0, 16'h0000, ST_OK);
    end
  endtask

  task automatic make_packet();
    int kind;
    int ihl;
    int off;
    int hdr_len;
    int cut;
    pkt_bytes.delete();
    kind = $urandom_range(0, 99);
    pkt_md = 1'($urandom_range(0, 1));
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ihl = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
    pkt_bytes.push_back({($urandom_range(0, 1) != 0) ? 4'h4 : 4'($urandom_range(0, 15)),
                         4'(ihl)});
    while (pkt_bytes.size() < ((ihl < 5) ? 20 : ihl * 4))
      pkt_bytes.push_back(8'($urandom_range(0, 255)));
    if (pkt_md == MODE_TCP) begin
      off = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
      hdr_len = (off < 5) ? 20 : off * 4;
      for (int i = 0; i < hdr_len; i++) begin
        pkt_bytes.push_back((i == 12) ? {4'(off), 4'($urandom_range(0, 15))}
                                      : 8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 17)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic run_random(input int byte_goal, input int pkt_goal);
    int nbytes;
    int npkts;
    nbytes = 0;
    npkts  = 0;
    while (nbytes < byte_goal || npkts < pkt_goal) begin
      make_packet();
      send_packet();
      nbytes += pkt_bytes.size();
      npkts++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cks_expected.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cks_expected.size() == 0) begin
        $display("%0t ns: result with nothing pending: checksum %h status %0d",
                 $time, checksum, status);
        mismatches++;
      end else begin
        want = cks_expected.pop_front();
        if (checksum !== want.cks) begin
          $display("%0t ns: checksum expected %h actual %h", $time, want.cks, checksum);
          mismatches++;
        end
        if (status !== want.st) begin
          $display("%0t ns: status expected %0d actual %0d", $time, want.st, status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 19;
    recv_idle_pct <= 86;
    foreach (dir_tab[k]) begin
      send_byte(dir_tab[k].md, dir_tab[k].d, dir_tab[k].lst, dir_tab[k].typed,
                dir_tab[k].cks, dir_tab[k].st);
    end
    run_random(RANDOM_BYTES / 3, PHASE_PACKETS);

    send_idle_pct = 86;
    recv_idle_pct <= 19;
    run_random(RANDOM_BYTES / 6, PHASE_PACKETS / 2);
    wait_drained();
    run_random(RANDOM_BYTES / 6, PHASE_PACKETS / 2);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (24) begin
      pkt_bytes.delete();
      pkt_md = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      send_packet();
    end

    run_random(RANDOM_BYTES / 3, PHASE_PACKETS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
